>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent checks shared by the rtl, reset disables them
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/qkc_pkg.sv
// ----------------------------------------------------------------------------
// qkc_pkg
// types, register indexes and the phase table of the quadrature knob counter
// ----------------------------------------------------------------------------
package qkc_pkg;

	localparam int unsigned VAL_W  = 32;
	localparam int unsigned WIN_W  = 16;
	localparam int unsigned STEP_W = 8;
	localparam int unsigned IDX_W  = 3;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_COUNT_STYLE  = 3'd0;
	localparam logic [IDX_W-1:0] REG_MIN_VALUE    = 3'd1;
	localparam logic [IDX_W-1:0] REG_MAX_VALUE    = 3'd2;
	localparam logic [IDX_W-1:0] REG_START_VALUE  = 3'd3;
	localparam logic [IDX_W-1:0] REG_BOOST_EN     = 3'd4;
	localparam logic [IDX_W-1:0] REG_BOOST_WINDOW = 3'd5;
	localparam logic [IDX_W-1:0] REG_BOOST_STEP   = 3'd6;

	localparam logic STYLE_BOUNDED = 1'b0;
	localparam logic STYLE_WRAP    = 1'b1;

	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

	localparam logic DIR_INCR = 1'b0;
	localparam logic DIR_DECR = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_CW1  = 3'd1,
		PH_CW2  = 3'd2,
		PH_CW3  = 3'd3,
		PH_CCW1 = 3'd4,
		PH_CCW2 = 3'd5,
		PH_CCW3 = 3'd6
	} phase_t;

	typedef struct packed {
		phase_t nxt;
		logic   up;
		logic   down;
	} phase_step_t;

	// pins = {pin_a, pin_b}; both high always goes back to idle
	function automatic phase_step_t next_phase(input phase_t ph, input logic [1:0] pins);
		phase_step_t r;
		r.up   = 1'b0;
		r.down = 1'b0;
		r.nxt  = PH_IDLE;
		case (ph)
			PH_CW1: begin
				case (pins)
					2'b00: r.nxt = PH_CW2;
					2'b01: r.nxt = PH_CW1;
					2'b10: r.nxt = PH_CW1;
					default: r.nxt = PH_IDLE;
				endcase
			end
			PH_CW2: begin
				case (pins)
					2'b00: r.nxt = PH_CW2;
					2'b01: r.nxt = PH_CW1;
					2'b10: r.nxt = PH_CW3;
					default: r.nxt = PH_IDLE;
				endcase
			end
			PH_CW3: begin
				case (pins)
					2'b00: r.nxt = PH_CW2;
					2'b01: r.nxt = PH_CW3;
					2'b10: r.nxt = PH_CW3;
					default: begin
						r.nxt = PH_IDLE;
						r.up  = 1'b1;
					end
				endcase
			end
			PH_CCW1: begin
				case (pins)
					2'b00: r.nxt = PH_CCW2;
					2'b01: r.nxt = PH_CCW1;
					2'b10: r.nxt = PH_CCW1;
					default: r.nxt = PH_IDLE;
				endcase
			end
			PH_CCW2: begin
				case (pins)
					2'b00: r.nxt = PH_CCW2;
					2'b01: r.nxt = PH_CCW3;
					2'b10: r.nxt = PH_CCW1;
					default: r.nxt = PH_IDLE;
				endcase
			end
			PH_CCW3: begin
				case (pins)
					2'b00: r.nxt = PH_CCW2;
					2'b01: r.nxt = PH_CCW3;
					2'b10: r.nxt = PH_CCW3;
					default: begin
						r.nxt  = PH_IDLE;
						r.down = 1'b1;
					end
				endcase
			end
			default: begin
				// idle and the unused code
				case (pins)
					2'b01: r.nxt = PH_CW1;
					2'b10: r.nxt = PH_CCW1;
					default: r.nxt = PH_IDLE;
				endcase
			end
		endcase
		return r;
	endfunction

endpackage

>>> design/quadrature_knob_counter.sv
// a request is registered in the input register, then decoded; its result is held in the output register
// throughput: one request per cycle while the output is not stalled, set by the single decode stage and output register
// a stalled output holds the decode stage; ticks and samples then wait in the input register
// reset (arst_n low, asynchronous): phase idle, count = 0, tick and history cleared,
// configuration registers return to their defaults
// ----------------------------------------------------------------------------
// quadrature_knob_counter
// debounced two-pin knob decoder with boost step and bounded or wrapping count
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quadrature_knob_counter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [qkc_pkg::IDX_W-1:0]            cfg_index,
	input  logic [qkc_pkg::VAL_W-1:0]            cfg_data,
	// input items
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 func,
	input  logic                                 pin_a,
	input  logic                                 pin_b,
	// results
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 direction,
	output logic signed [qkc_pkg::VAL_W-1:0]     new_value
);

	localparam int unsigned W = qkc_pkg::VAL_W;
	localparam int unsigned XW = W + 2;

	typedef enum logic [1:0] {
		LAST_NONE = 2'd0,
		LAST_UP   = 2'd1,
		LAST_DOWN = 2'd2
	} last_dir_t;

	// configuration registers
	logic                          style_q;
	logic [W-1:0]                  min_q;
	logic [W-1:0]                  max_q;
	logic                          boost_en_q;
	logic [qkc_pkg::WIN_W-1:0]     window_q;
	logic [qkc_pkg::STEP_W-1:0]    boost_step_q;

	// state
	qkc_pkg::phase_t               phase_q;
	logic [W-1:0]                  count_q;
	logic [W-1:0]                  tick_q;
	logic [W-1:0]                  last_tick_q;
	last_dir_t                     last_dir_q;

	// input register
	logic                          valid_s1;
	logic                          func_s1;
	logic [1:0]                    pins_s1;

	// output register
	logic                          out_valid_q;
	logic                          dir_q;
	logic [W-1:0]                  value_q;

	logic                          go;
	logic                          cfg_wr;
	qkc_pkg::phase_step_t          ps;
	logic                          is_count;
	logic [W-1:0]                  elapsed;
	logic                          boost;
	logic signed [XW-1:0]          val_x;
	logic signed [XW-1:0]          lo_x;
	logic signed [XW-1:0]          hi_x;
	logic signed [XW-1:0]          step_x;
	logic signed [XW-1:0]          room;
	logic signed [XW-1:0]          next_x;
	logic                          at_limit;
	logic                          emit;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	// the decode stage moves when the output slot is free or being emptied
	assign go       = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | go;

	assign out_valid = out_valid_q;
	assign direction = dir_q;
	assign new_value = value_q;

	always_comb begin
		ps       = qkc_pkg::next_phase(phase_q, pins_s1);
		is_count = (func_s1 == qkc_pkg::FUNC_SAMPLE) & (ps.up | ps.down);
		elapsed  = tick_q - last_tick_q;
		boost    = boost_en_q & (elapsed < {{(W - qkc_pkg::WIN_W){1'b0}}, window_q})
		         & ((ps.up & (last_dir_q == LAST_UP)) | (ps.down & (last_dir_q == LAST_DOWN)));
		val_x    = $signed({{2{count_q[W-1]}}, count_q});
		lo_x     = $signed({{2{min_q[W-1]}}, min_q});
		hi_x     = $signed({{2{max_q[W-1]}}, max_q});
		step_x   = boost ? $signed({{(XW - qkc_pkg::STEP_W){1'b0}}, boost_step_q})
		                 : $signed({{(XW - 1){1'b0}}, 1'b1});
		if (ps.up) begin
			room     = hi_x - val_x;
			at_limit = (style_q == qkc_pkg::STYLE_BOUNDED) & (val_x == hi_x);
			if (room >= step_x) begin
				next_x = val_x + step_x;
			end else if (style_q == qkc_pkg::STYLE_BOUNDED) begin
				next_x = hi_x;
			end else begin
				next_x = lo_x + room;
			end
		end else begin
			room     = val_x - lo_x;
			at_limit = (style_q == qkc_pkg::STYLE_BOUNDED) & (val_x == lo_x);
			if (room >= step_x) begin
				next_x = val_x - step_x;
			end else if (style_q == qkc_pkg::STYLE_BOUNDED) begin
				next_x = lo_x;
			end else begin
				next_x = hi_x - room;
			end
		end
		emit = is_count & ~at_limit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1 <= func;
			pins_s1 <= {pin_a, pin_b};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			style_q      <= qkc_pkg::STYLE_WRAP;
			min_q        <= '0;
			max_q        <= W'(100);
			boost_en_q   <= 1'b0;
			window_q     <= qkc_pkg::WIN_W'(100);
			boost_step_q <= qkc_pkg::STEP_W'(5);
			phase_q      <= qkc_pkg::PH_IDLE;
			count_q      <= '0;
			tick_q       <= '0;
			last_tick_q  <= '0;
			last_dir_q   <= LAST_NONE;
		end else begin
			if (go) begin
				if (func_s1 == qkc_pkg::FUNC_TICK) begin
					tick_q <= tick_q + W'(1);
				end else begin
					phase_q <= ps.nxt;
					if (is_count) begin
						last_tick_q <= tick_q;
						last_dir_q  <= ps.up ? LAST_UP : LAST_DOWN;
					end
					if (emit) begin
						count_q <= next_x[W-1:0];
					end
				end
			end
			if (cfg_wr) begin
				case (cfg_index)
					qkc_pkg::REG_COUNT_STYLE:  style_q      <= cfg_data[0];
					qkc_pkg::REG_MIN_VALUE:    min_q        <= cfg_data;
					qkc_pkg::REG_MAX_VALUE:    max_q        <= cfg_data;
					qkc_pkg::REG_START_VALUE:  count_q      <= cfg_data;
					qkc_pkg::REG_BOOST_EN:     boost_en_q   <= cfg_data[0];
					qkc_pkg::REG_BOOST_WINDOW: window_q     <= cfg_data[qkc_pkg::WIN_W-1:0];
					qkc_pkg::REG_BOOST_STEP:   boost_step_q <= cfg_data[qkc_pkg::STEP_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			dir_q   <= ps.up ? qkc_pkg::DIR_INCR : qkc_pkg::DIR_DECR;
			value_q <= next_x[W-1:0];
		end
	end

	// a counted result matches the stored count
	`ASSERT_NEXT(a_value_tracks_count, clk, arst_n, go && emit && !(cfg_wr && cfg_index == qkc_pkg::REG_START_VALUE), out_valid && new_value == count_q, "result differs from count")
	// a full loop stamps the current tick
	`ASSERT_NEXT(a_stamp_tick, clk, arst_n, go && is_count, last_tick_q == tick_q, "count event did not record tick")
	// an empty input register always takes a request
	`ASSERT_SAME(a_ready_when_empty, clk, arst_n, !valid_s1, in_ready, "input stalled while empty")

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// checks the quadrature knob counter: knob turns, bounce and ticks go in under
// random stalls, a local model of the phase machine and counter predicts every
// count change, and each change that comes out is compared field by field
// ----------------------------------------------------------------------------
module tb_top;

	localparam int MAX_SHOWN      = 10;
	localparam int SETTLE_CYCLES  = 8;
	localparam int CALM_TAIL      = 100;
	localparam int NUM_PHASES     = 8;
	localparam int PHASE_ITEMS    = 90;
	localparam int DRAIN_LIMIT    = 2000;

	localparam logic signed [qkc_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [qkc_pkg::VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	typedef enum logic [1:0] {
		TURN_NONE = 2'd0,
		TURN_UP   = 2'd1,
		TURN_DOWN = 2'd2
	} turn_t;

	// one request: either a register write or an input item
	typedef struct packed {
		logic                      is_cfg;
		logic [qkc_pkg::IDX_W-1:0] idx;
		logic [qkc_pkg::VAL_W-1:0] data;
		logic                      func;
		logic                      a;
		logic                      b;
	} knob_req_t;

	typedef struct packed {
		logic                             direction;
		logic signed [qkc_pkg::VAL_W-1:0] value;
	} count_change_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [qkc_pkg::IDX_W-1:0] cfg_index = '0;
	logic [qkc_pkg::VAL_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic func = 1'b0;
	logic pin_a = 1'b1;
	logic pin_b = 1'b1;
	logic out_valid;
	logic out_ready = 1'b0;
	logic direction;
	logic signed [qkc_pkg::VAL_W-1:0] new_value;

	knob_req_t knob_reqs[$];
	count_change_t pending_changes[$];
	int changes_predicted = 0;
	int changes_received = 0;
	int errors = 0;

	// idling control
	logic calm = 1'b0;
	int in_idle_pct = 0;
	int out_idle_pct = 0;
	logic [5:0] mode_timer = '0;
	int in_gap = 0;
	int out_gap = 0;
	int since_accept = 0;

	// local copy of the configuration
	logic style_r;
	logic signed [qkc_pkg::VAL_W-1:0] min_r;
	logic signed [qkc_pkg::VAL_W-1:0] max_r;
	logic signed [qkc_pkg::VAL_W-1:0] start_r;
	logic boost_en_r;
	logic [qkc_pkg::WIN_W-1:0] window_r;
	logic [qkc_pkg::STEP_W-1:0] bstep_r;

	// local copy of the state
	qkc_pkg::phase_t knob_phase;
	logic signed [qkc_pkg::VAL_W-1:0] knob_count;
	logic [qkc_pkg::VAL_W-1:0] tick_now;
	logic [qkc_pkg::VAL_W-1:0] last_tick;
	turn_t last_turn;

	quadrature_knob_counter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.pin_a     (pin_a),
		.pin_b     (pin_b),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.direction (direction),
		.new_value (new_value)
	);

	always #1 clk = ~clk;

	function automatic void flag_error(string msg);
		errors++;
		if (errors <= MAX_SHOWN) begin
			$display("%s", msg);
		end
	endfunction

	function automatic void knob_reset();
		style_r = qkc_pkg::STYLE_WRAP;
		min_r = 0;
		max_r = 100;
		start_r = 0;
		boost_en_r = 1'b0;
		window_r = 100;
		bstep_r = 5;
		knob_phase = qkc_pkg::PH_IDLE;
		knob_count = 0;
		tick_now = '0;
		last_tick = '0;
		last_turn = TURN_NONE;
	endfunction

	function automatic void knob_configure(logic [qkc_pkg::IDX_W-1:0] idx,
			logic [qkc_pkg::VAL_W-1:0] data);
		case (idx)
			qkc_pkg::REG_COUNT_STYLE: style_r = data[0];
			qkc_pkg::REG_MIN_VALUE: min_r = data;
			qkc_pkg::REG_MAX_VALUE: max_r = data;
			qkc_pkg::REG_START_VALUE: begin
				start_r = data;
				knob_count = data;
			end
			qkc_pkg::REG_BOOST_EN: boost_en_r = data[0];
			qkc_pkg::REG_BOOST_WINDOW: window_r = data[qkc_pkg::WIN_W-1:0];
			qkc_pkg::REG_BOOST_STEP: bstep_r = data[qkc_pkg::STEP_W-1:0];
			default: ;
		endcase
	endfunction

	// pins = {a, b}; a low level means the contact is closed
	function automatic qkc_pkg::phase_t knob_advance(qkc_pkg::phase_t p, logic [1:0] pins,
			output logic up, output logic dn);
		up = 1'b0;
		dn = 1'b0;
		if (pins == 2'b11) begin
			up = (p == qkc_pkg::PH_CW3);
			dn = (p == qkc_pkg::PH_CCW3);
			return qkc_pkg::PH_IDLE;
		end
		if (pins == 2'b00) begin
			case (p)
				qkc_pkg::PH_CW1, qkc_pkg::PH_CW2, qkc_pkg::PH_CW3:
					return qkc_pkg::PH_CW2;
				qkc_pkg::PH_CCW1, qkc_pkg::PH_CCW2, qkc_pkg::PH_CCW3:
					return qkc_pkg::PH_CCW2;
				default: return qkc_pkg::PH_IDLE;
			endcase
		end
		case (p)
			qkc_pkg::PH_CW1: return qkc_pkg::PH_CW1;
			qkc_pkg::PH_CW2: return (pins == 2'b10) ? qkc_pkg::PH_CW3 : qkc_pkg::PH_CW1;
			qkc_pkg::PH_CW3: return qkc_pkg::PH_CW3;
			qkc_pkg::PH_CCW1: return qkc_pkg::PH_CCW1;
			qkc_pkg::PH_CCW2: return (pins == 2'b01) ? qkc_pkg::PH_CCW3 : qkc_pkg::PH_CCW1;
			qkc_pkg::PH_CCW3: return qkc_pkg::PH_CCW3;
			default: return (pins == 2'b01) ? qkc_pkg::PH_CW1 : qkc_pkg::PH_CCW1;
		endcase
	endfunction

	function automatic void predict_knob_item(knob_req_t r);
		logic up;
		logic dn;
		logic moved;
		logic [qkc_pkg::VAL_W-1:0] elapsed;
		longint val;
		longint lo;
		longint hi;
		longint stp;
		count_change_t chg;
		if (r.func == qkc_pkg::FUNC_TICK) begin
			tick_now = tick_now + 1;
			return;
		end
		knob_phase = knob_advance(knob_phase, {r.a, r.b}, up, dn);
		if (!up && !dn) begin
			return;
		end
		val = knob_count;
		lo = min_r;
		hi = max_r;
		stp = 1;
		elapsed = tick_now - last_tick;
		if (boost_en_r && elapsed < {{(qkc_pkg::VAL_W-qkc_pkg::WIN_W){1'b0}}, window_r} &&
				((up && last_turn == TURN_UP) || (dn && last_turn == TURN_DOWN))) begin
			stp = bstep_r;
		end
		moved = 1'b1;
		if (up) begin
			if (style_r == qkc_pkg::STYLE_BOUNDED && val == hi) moved = 1'b0;
			else if (hi - val >= stp) val = val + stp;
			else if (style_r == qkc_pkg::STYLE_BOUNDED) val = hi;
			else val = lo + (hi - val);
		end else begin
			if (style_r == qkc_pkg::STYLE_BOUNDED && val == lo) moved = 1'b0;
			else if (val - lo >= stp) val = val - stp;
			else if (style_r == qkc_pkg::STYLE_BOUNDED) val = lo;
			else val = hi - (val - lo);
		end
		last_tick = tick_now;
		last_turn = up ? TURN_UP : TURN_DOWN;
		if (moved) begin
			knob_count = val[qkc_pkg::VAL_W-1:0];
			chg.direction = up ? qkc_pkg::DIR_INCR : qkc_pkg::DIR_DECR;
			chg.value = knob_count;
			pending_changes.push_back(chg);
			changes_predicted++;
		end
	endfunction

	task automatic push_cfg(logic [qkc_pkg::IDX_W-1:0] idx, logic [qkc_pkg::VAL_W-1:0] data);
		knob_req_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.data = data;
		knob_reqs.push_back(r);
	endtask

	task automatic push_sample(logic [1:0] pins);
		knob_req_t r;
		r = '0;
		r.func = qkc_pkg::FUNC_SAMPLE;
		r.a = pins[1];
		r.b = pins[0];
		knob_reqs.push_back(r);
	endtask

	task automatic push_tick(int n);
		knob_req_t r;
		r = '0;
		r.func = qkc_pkg::FUNC_TICK;
		r.a = $urandom_range(0, 1);
		r.b = $urandom_range(0, 1);
		repeat (n) knob_reqs.push_back(r);
	endtask

	// steps below 3 leave the loop unfinished before both pins go high
	task automatic push_turn(logic cw, logic bouncy, int steps);
		logic [1:0] seq [3];
		seq[0] = cw ? 2'b01 : 2'b10;
		seq[1] = 2'b00;
		seq[2] = cw ? 2'b10 : 2'b01;
		for (int i = 0; i < steps; i++) begin
			push_sample(seq[i]);
			if (bouncy && $urandom_range(0, 2) == 0) begin
				// contact bounce: fall back one position, then forward again
				push_sample(i == 0 ? 2'b11 : seq[i - 1]);
				push_sample(seq[i]);
			end
		end
		push_sample(2'b11);
	endtask

	task automatic push_settings(int p);
		logic style;
		logic boost;
		logic signed [qkc_pkg::VAL_W-1:0] lo;
		logic signed [qkc_pkg::VAL_W-1:0] hi;
		logic signed [qkc_pkg::VAL_W-1:0] start;
		logic [qkc_pkg::WIN_W-1:0] window;
		logic [qkc_pkg::STEP_W-1:0] step;
		int span;
		style = $urandom_range(0, 1);
		boost = $urandom_range(0, 1);
		case ($urandom_range(0, 4))
			0: window = '0;
			1: window = 1;
			2: window = 3;
			3: window = '1;
			default: window = $urandom_range(0, 65535);
		endcase
		case ($urandom_range(0, 4))
			0: step = '0;
			1: step = 1;
			2: step = '1;
			default: step = $urandom_range(1, 255);
		endcase
		case (p)
			0: begin
				style = qkc_pkg::STYLE_BOUNDED;
				lo = VAL_MIN;
				hi = VAL_MAX;
				start = VAL_MAX - 2;
				boost = 1'b1;
				window = '1;
				step = '1;
			end
			1: begin
				style = qkc_pkg::STYLE_WRAP;
				lo = VAL_MIN;
				hi = VAL_MAX;
				start = VAL_MIN + 2;
				boost = 1'b1;
				window = '1;
				step = '1;
			end
			2: begin
				style = qkc_pkg::STYLE_BOUNDED;
				lo = 10;
				hi = -10;
				start = 0;
			end
			3: begin
				style = qkc_pkg::STYLE_WRAP;
				lo = 10;
				hi = -10;
				start = 0;
			end
			4: begin
				style = qkc_pkg::STYLE_BOUNDED;
				lo = VAL_MIN;
				hi = VAL_MIN + 5;
				start = VAL_MIN + 1;
			end
			default: begin
				lo = $urandom_range(0, 40) - 20;
				span = $urandom_range(0, 30);
				hi = lo + span;
				case ($urandom_range(0, 5))
					0: start = lo - 3;
					1: start = hi + 3;
					default: start = lo + $urandom_range(0, span);
				endcase
			end
		endcase
		push_cfg(qkc_pkg::REG_COUNT_STYLE, {{(qkc_pkg::VAL_W-1){1'b0}}, style});
		push_cfg(qkc_pkg::REG_MIN_VALUE, lo);
		push_cfg(qkc_pkg::REG_MAX_VALUE, hi);
		push_cfg(qkc_pkg::REG_BOOST_EN, {{(qkc_pkg::VAL_W-1){1'b0}}, boost});
		push_cfg(qkc_pkg::REG_BOOST_WINDOW,
			{{(qkc_pkg::VAL_W-qkc_pkg::WIN_W){1'b0}}, window});
		push_cfg(qkc_pkg::REG_BOOST_STEP, {{(qkc_pkg::VAL_W-qkc_pkg::STEP_W){1'b0}}, step});
		push_cfg(qkc_pkg::REG_START_VALUE, start);
	endtask

	task automatic push_random_items(int n);
		int stop_at;
		int pick;
		stop_at = knob_reqs.size() + n;
		while (knob_reqs.size() < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) push_turn($urandom_range(0, 1), $urandom_range(0, 3) == 0, 3);
			else if (pick < 80) push_tick($urandom_range(1, 4));
			else if (pick < 92) repeat ($urandom_range(1, 3)) push_sample($urandom_range(0, 3));
			else push_turn($urandom_range(0, 1), 1'b0, $urandom_range(0, 2));
		end
	endtask

	always @(posedge clk) begin
		mode_timer <= mode_timer + 6'd1;
		if (mode_timer == 0) begin
			in_idle_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
			out_idle_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
		end
	end

	// driver: presents register writes and input items in queue order
	always @(posedge clk or negedge arst_n) begin
		logic next_in_valid;
		logic next_cfg_valid;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_valid <= 1'b0;
			func <= qkc_pkg::FUNC_SAMPLE;
			pin_a <= 1'b1;
			pin_b <= 1'b1;
			cfg_index <= qkc_pkg::REG_COUNT_STYLE;
			cfg_data <= '0;
			knob_reset();
			in_gap = 0;
			since_accept = SETTLE_CYCLES;
		end else begin
			next_in_valid = in_valid;
			next_cfg_valid = cfg_valid;
			if (in_valid && in_ready) begin
				predict_knob_item(knob_reqs[0]);
				void'(knob_reqs.pop_front());
				next_in_valid = 1'b0;
				since_accept = 0;
			end else if (since_accept < SETTLE_CYCLES) begin
				since_accept++;
			end
			if (cfg_valid && cfg_ready) begin
				knob_configure(knob_reqs[0].idx, knob_reqs[0].data);
				void'(knob_reqs.pop_front());
				next_cfg_valid = 1'b0;
			end
			if (!next_in_valid && !next_cfg_valid && knob_reqs.size() != 0) begin
				if (knob_reqs[0].is_cfg) begin
					// registers change only once the counter has gone quiet
					if (changes_predicted == changes_received && since_accept >= SETTLE_CYCLES) begin
						cfg_index <= knob_reqs[0].idx;
						cfg_data <= knob_reqs[0].data;
						next_cfg_valid = 1'b1;
					end
				end else if (in_gap > 0) begin
					in_gap--;
				end else if (!calm && $urandom_range(0, 99) < in_idle_pct) begin
					in_gap = $urandom_range(0, 18);
				end else begin
					func <= knob_reqs[0].func;
					pin_a <= knob_reqs[0].a;
					pin_b <= knob_reqs[0].b;
					next_in_valid = 1'b1;
				end
			end
			in_valid <= next_in_valid;
			cfg_valid <= next_cfg_valid;
			calm <= (knob_reqs.size() <= CALM_TAIL);
		end
	end

	// monitor: takes count changes and compares them with the predicted ones
	always @(posedge clk or negedge arst_n) begin
		count_change_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_gap = 0;
		end else begin
			if (out_valid && out_ready) begin
				changes_received <= changes_received + 1;
				if (pending_changes.size() == 0) begin
					flag_error($sformatf("unexpected count change: dir %0d value %0d",
						direction, new_value));
				end else begin
					want = pending_changes.pop_front();
					if (direction !== want.direction || new_value !== want.value) begin
						flag_error($sformatf(
							"count change mismatch: expected dir %0d value %0d, got dir %0d value %0d",
							want.direction, want.value, direction, new_value));
					end
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < out_idle_pct) begin
				out_gap = $urandom_range(0, 18);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int drain_left;
		// reset settings: wrap between 0 and 100
		push_tick(1);
		push_sample(2'b11);
		push_sample(2'b00);
		push_turn(1'b1, 1'b0, 3);
		push_turn(1'b0, 1'b0, 3);
		// down through min, then up through max
		push_turn(1'b0, 1'b0, 3);
		push_turn(1'b1, 1'b0, 3);
		push_turn(1'b1, 1'b0, 2);
		for (int p = 0; p < NUM_PHASES; p++) begin
			push_settings(p);
			push_random_items(PHASE_ITEMS);
		end

		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (knob_reqs.size() != 0) @(negedge clk);
		drain_left = DRAIN_LIMIT;
		while (changes_predicted != changes_received && drain_left > 0) begin
			@(negedge clk);
			drain_left--;
		end
		repeat (10) @(negedge clk);
		if (pending_changes.size() != 0) begin
			flag_error($sformatf("%0d predicted count changes never came out",
				pending_changes.size()));
		end
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
